FILE: src/fpjs_pkg.sv
// Shared constants and types for the frame packet image-marker splitter.
`default_nettype none

package fpjs_pkg;

  localparam int BYTE_W    = 8;
  localparam int FRAME_W   = 12;
  localparam int PAYLOAD_W = 11;
  localparam int PTR_W     = 16;
  localparam int SKIP_W    = 4;
  localparam int CFG_IDX_W = 1;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [FRAME_W-1:0]   frame_len_t;
  typedef logic [PAYLOAD_W-1:0] payload_len_t;
  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [SKIP_W-1:0]    skip_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_BYTES   = 1'b0,
    CFG_PAYLOAD_BYTES = 1'b1
  } cfg_idx_t;

  localparam frame_len_t   FRAME_BYTES_RESET   = 12'd1024;
  localparam payload_len_t PAYLOAD_BYTES_RESET = 11'd1003;

  // Frame layout.
  localparam frame_len_t TYPE_OFFSET    = 12'd5;
  localparam frame_len_t PTR_LO_OFFSET  = 12'd19;
  localparam frame_len_t PTR_HI_OFFSET  = 12'd20;
  localparam frame_len_t PAYLOAD_OFFSET = 12'd21;
  localparam byte_t      TYPE_DATA      = 8'd217;

  // Image start marker FF D8 FF E0.
  localparam byte_t MARK_0 = 8'hFF;
  localparam byte_t MARK_1 = 8'hD8;
  localparam byte_t MARK_2 = 8'hFF;
  localparam byte_t MARK_3 = 8'hE0;

  typedef struct packed {
    byte_t out_byte;
    logic  image_start;
  } result_t;

endpackage

`default_nettype wire

FILE: src/fpjs_in_if.sv
// Input byte channel: valid/ready handshake with one raw stream byte.
`default_nettype none

interface fpjs_in_if import fpjs_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

FILE: src/fpjs_out_if.sv
// Result channel: valid/ready handshake with one picture byte and its marker flag.
`default_nettype none

interface fpjs_out_if import fpjs_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  image_start;

  modport source (output valid, output out_byte, output image_start, input ready);
  modport sink   (input valid, input out_byte, input image_start, output ready);
endinterface

`default_nettype wire

FILE: src/frame_packet_jpeg_splitter_unit.sv
// Top level: frame deframer, packet header drop, image marker flagging and output buffer.
//
//   Channel   Dir   Handshake        Payload
//   in_ch     in    valid / ready    in_byte (8)
//   out_ch    out   valid / ready    out_byte (8), image_start (1)
//   cfg_*     in    cfg_we           cfg_index (1), cfg_wdata (12)
//
// One input byte is taken per cycle while in_ch.ready is high; a result, if the byte
// makes one, goes to the output register, or to the skid register while the output
// register holds an item not yet taken. Frame position, pointer and header count update
// at the edge that accepts the byte. The two-entry output buffer keeps in_ch.ready
// high while one result waits; it drops only when both are full. Reset is synchronous.
`default_nettype none

module frame_packet_jpeg_splitter_unit import fpjs_pkg::*; #(
  parameter int MAX_FRAME_BYTES     = 2048,
  parameter int PACKET_HEADER_BYTES = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  fpjs_in_if.sink                   in_ch,
  fpjs_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FRAME_W-1:0]   cfg_wdata
);

  // The frame length register is 12 bits, so the cap only matters below 4096.
  localparam int         LEN_CAP_INT = (MAX_FRAME_BYTES > 4095) ? 4095 : MAX_FRAME_BYTES;
  localparam frame_len_t LEN_CAP     = FRAME_W'(LEN_CAP_INT);
  localparam skip_t      SKIP_RESET  = SKIP_W'(PACKET_HEADER_BYTES % 16);

  frame_len_t   frame_bytes_r;
  payload_len_t payload_bytes_r;

  frame_len_t pos_r, pos_nxt;
  logic       is_data_r, is_data_nxt;
  ptr_t       ptr_r, ptr_nxt;
  skip_t      skip_r, skip_nxt;
  byte_t      win_r [3];
  byte_t      win_nxt [3];
  logic [1:0] fill_r, fill_nxt;

  result_t res_r, skid_r, push_res;
  logic    res_valid_r, skid_valid_r;

  frame_len_t len;
  frame_len_t rel;
  logic       in_fire;
  logic       in_payload;
  logic       packet_byte;
  skip_t      skip_eff;
  logic       push;
  logic       pop;
  logic [FRAME_W:0] pos_inc;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_bytes_r   <= FRAME_BYTES_RESET;
      payload_bytes_r <= PAYLOAD_BYTES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_BYTES:   frame_bytes_r   <= cfg_wdata;
        CFG_PAYLOAD_BYTES: payload_bytes_r <= cfg_wdata[PAYLOAD_W-1:0];
        default:           frame_bytes_r   <= frame_bytes_r;
      endcase
    end
  end

  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign len        = (frame_bytes_r > LEN_CAP) ? LEN_CAP : frame_bytes_r;
  assign rel        = pos_r - PAYLOAD_OFFSET;
  assign in_payload = (pos_r >= PAYLOAD_OFFSET) && (pos_r < len);
  assign packet_byte = in_payload && (rel < {1'b0, payload_bytes_r}) && is_data_r &&
                       (ptr_r <= {{(PTR_W-PAYLOAD_W){1'b0}}, payload_bytes_r});
  // The pointer marks the first byte of a new packet, which restarts the header drop.
  assign skip_eff = ({{(PTR_W-FRAME_W){1'b0}}, rel} == ptr_r) ? SKIP_RESET : skip_r;
  assign pos_inc  = {1'b0, pos_r} + 1'b1;

  always_comb begin
    pos_nxt     = pos_r;
    is_data_nxt = is_data_r;
    ptr_nxt     = ptr_r;
    skip_nxt    = skip_r;
    win_nxt     = win_r;
    fill_nxt    = fill_r;
    push        = 1'b0;
    push_res.out_byte    = win_r[0];
    push_res.image_start = (win_r[0] == MARK_0) && (win_r[1] == MARK_1) &&
                           (win_r[2] == MARK_2) && (in_ch.in_byte == MARK_3);
    if (in_fire) begin
      if (pos_r == TYPE_OFFSET) begin
        is_data_nxt = (in_ch.in_byte == TYPE_DATA);
      end else if (pos_r == PTR_LO_OFFSET) begin
        ptr_nxt[7:0] = in_ch.in_byte;
      end else if (pos_r == PTR_HI_OFFSET) begin
        ptr_nxt[15:8] = in_ch.in_byte;
      end else if (packet_byte) begin
        if (skip_eff != '0) begin
          skip_nxt = skip_eff - 1'b1;
        end else begin
          skip_nxt = skip_eff;
          if (fill_r != 2'd3) begin
            win_nxt[fill_r] = in_ch.in_byte;
            fill_nxt        = fill_r + 1'b1;
          end else begin
            win_nxt[0] = win_r[1];
            win_nxt[1] = win_r[2];
            win_nxt[2] = in_ch.in_byte;
            push       = 1'b1;
          end
        end
      end
      pos_nxt = (pos_inc >= {1'b0, len}) ? '0 : pos_inc[FRAME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      is_data_r <= 1'b0;
      ptr_r     <= '0;
      skip_r    <= SKIP_RESET;
      fill_r    <= 2'd0;
    end else begin
      pos_r     <= pos_nxt;
      is_data_r <= is_data_nxt;
      ptr_r     <= ptr_nxt;
      skip_r    <= skip_nxt;
      fill_r    <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  // Output register with a skid entry behind it.
  assign pop = res_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!res_valid_r || pop) begin
      if (skid_valid_r) begin
        res_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end else begin
        res_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid_r || pop) begin
      if (skid_valid_r) begin
        res_r  <= skid_r;
        skid_r <= push_res;
      end else begin
        res_r  <= push_res;
      end
    end else if (push) begin
      skid_r <= push_res;
    end
  end

  assign out_ch.valid       = res_valid_r;
  assign out_ch.out_byte    = res_r.out_byte;
  assign out_ch.image_start = res_r.image_start;

endmodule

`default_nettype wire

FILE: tb/frame_packet_jpeg_splitter_unit_tb.sv
// Self-checking testbench: random framed byte streams against a deframing predictor.
`timescale 1ns / 1ps

module frame_packet_jpeg_splitter_unit_tb;
  import fpjs_pkg::*;

  localparam int MAX_FRAME   = 2048;
  localparam int HDR_BYTES   = 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int ITEM_TARGET = 1550;

  typedef enum int {
    FLOW_FREE,
    FLOW_SENDER_GAPS,
    FLOW_RECEIVER_STALLS,
    FLOW_BOTH
  } flow_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  frame_len_t cfg_wdata;

  fpjs_in_if  in_ch ();
  fpjs_out_if out_ch ();

  frame_packet_jpeg_splitter_unit #(
    .MAX_FRAME_BYTES     (MAX_FRAME),
    .PACKET_HEADER_BYTES (HDR_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copy of the registers and the deframing state.
  frame_len_t   cfg_frame_bytes   = FRAME_BYTES_RESET;
  payload_len_t cfg_payload_bytes = PAYLOAD_BYTES_RESET;
  frame_len_t   fr_pos      = '0;
  logic         fr_is_data  = 1'b0;
  ptr_t         fr_ptr      = '0;
  skip_t        skip_left   = skip_t'(HDR_BYTES);
  byte_t        window [3]  = '{default: '0};
  logic [1:0]   window_fill = '0;

  byte_t   stream_bytes [$];
  result_t picture_due  [$];
  byte_t   marker_tail  [$];
  flow_t   flow = FLOW_FREE;
  int      fail_count   = 0;
  int      quiet_cycles = 0;
  int      items_sent   = 0;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_FRAME_BYTES;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    out_ch.ready = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic frame_len_t active_frame_len();
    return (cfg_frame_bytes > frame_len_t'(MAX_FRAME)) ? frame_len_t'(MAX_FRAME)
                                                      : cfg_frame_bytes;
  endfunction

  function automatic bit holds_off(bit receiver_side);
    case (flow)
      FLOW_SENDER_GAPS:     return !receiver_side && ($urandom_range(0, 99) < 87);
      FLOW_RECEIVER_STALLS: return receiver_side && ($urandom_range(0, 99) < 87);
      FLOW_BOTH:            return $urandom_range(0, 99) < 21;
      default:              return 1'b0;
    endcase
  endfunction

  // Appends one byte to the pending stream and counts it against the item budget.
  function automatic void queue_byte(byte_t b);
    stream_bytes = {stream_bytes, b};
    items_sent++;
  endfunction

  // Advances the frame state by one stream byte and queues the picture byte, if any.
  function automatic void deframe_byte(byte_t b);
    frame_len_t len;
    frame_len_t rel;
    result_t    pic;
    len = active_frame_len();
    if (fr_pos == TYPE_OFFSET) begin
      fr_is_data = (b == TYPE_DATA);
    end else if (fr_pos == PTR_LO_OFFSET) begin
      fr_ptr[7:0] = b;
    end else if (fr_pos == PTR_HI_OFFSET) begin
      fr_ptr[15:8] = b;
    end else if (fr_pos >= PAYLOAD_OFFSET && fr_pos < len) begin
      rel = fr_pos - PAYLOAD_OFFSET;
      if (rel < cfg_payload_bytes && fr_is_data && fr_ptr <= cfg_payload_bytes) begin
        if (rel == fr_ptr) begin
          skip_left = skip_t'(HDR_BYTES);
        end
        if (skip_left != 0) begin
          skip_left = skip_left - 1'b1;
        end else if (window_fill < 2'd3) begin
          window[window_fill] = b;
          window_fill = window_fill + 1'b1;
        end else begin
          pic.out_byte = window[0];
          pic.image_start = (window[0] == MARK_0) && (window[1] == MARK_1) &&
                            (window[2] == MARK_2) && (b == MARK_3);
          picture_due = {picture_due, pic};
          window[0] = window[1];
          window[1] = window[2];
          window[2] = b;
        end
      end
    end
    fr_pos = (fr_pos + 12'd1 >= len) ? '0 : fr_pos + 12'd1;
  endfunction

  // Stream driver: the item is predicted at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        deframe_byte(in_ch.in_byte);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (stream_bytes.size() != 0 && !holds_off(1'b0)) begin
          in_ch.valid <= 1'b1;
          in_ch.in_byte <= stream_bytes.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : picture_monitor
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (picture_due.size() == 0) begin
          $display("%0t: unexpected item, expected none, got byte %02h start %0b",
                   $time, out_ch.out_byte, out_ch.image_start);
          fail_count++;
        end else begin
          want = picture_due.pop_front();
          if (out_ch.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %02h, got %02h",
                     $time, want.out_byte, out_ch.out_byte);
            fail_count++;
          end
          if (out_ch.image_start !== want.image_start) begin
            $display("%0t: image_start expected %0b, got %0b",
                     $time, want.image_start, out_ch.image_start);
            fail_count++;
          end
        end
      end
      out_ch.ready <= !holds_off(1'b1);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic write_config(cfg_idx_t idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= frame_len_t'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FRAME_BYTES) begin
      cfg_frame_bytes = frame_len_t'(value);
    end else begin
      cfg_payload_bytes = payload_len_t'(value);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (stream_bytes.size() != 0 || in_ch.valid || picture_due.size() != 0);
    // A last byte that makes no picture byte may still be in flight.
    repeat (4) @(posedge clk);
  endtask

  // One frame: well formed most of the time, otherwise a bad type, a bad pointer or noise.
  task automatic send_frame(int len, int pay);
    int    eff;
    int    kind;
    int    k;
    ptr_t  ptr;
    byte_t type_byte;
    byte_t b;
    eff = (pay < len - 21) ? pay : len - 21;
    kind = $urandom_range(0, 9);
    type_byte = TYPE_DATA;
    if (kind == 0) begin
      type_byte = byte_t'($urandom_range(0, 255));
      if (type_byte == TYPE_DATA) type_byte = ~TYPE_DATA;
    end
    if (kind == 1) begin
      ptr = ptr_t'($urandom_range(pay + 1, 65535));
    end else if (eff < pay && $urandom_range(0, 3) == 0) begin
      ptr = ptr_t'($urandom_range(eff, pay));
    end else if ($urandom_range(0, 5) == 0) begin
      ptr = ptr_t'(pay);
    end else begin
      ptr = ptr_t'($urandom_range(0, eff));
    end
    for (k = 0; k < len; k++) begin
      if (kind == 2) begin
        b = byte_t'($urandom);
      end else if (k == TYPE_OFFSET) begin
        b = type_byte;
      end else if (k == PTR_LO_OFFSET) begin
        b = ptr[7:0];
      end else if (k == PTR_HI_OFFSET) begin
        b = ptr[15:8];
      end else if (k >= PAYLOAD_OFFSET && k < PAYLOAD_OFFSET + eff) begin
        // Picture content is seeded with whole and broken image markers.
        if (marker_tail.size() != 0) begin
          b = marker_tail.pop_front();
        end else begin
          case ($urandom_range(0, 19))
            0: begin
              b = MARK_0;
              marker_tail = {MARK_1, MARK_2, MARK_3};
            end
            1: begin
              b = MARK_0;
              marker_tail = {MARK_1, MARK_2, byte_t'($urandom)};
            end
            2: b = MARK_1;
            3: b = MARK_3;
            default: b = byte_t'($urandom);
          endcase
        end
      end else begin
        b = byte_t'($urandom);
      end
      queue_byte(b);
    end
  endtask

  task automatic run_phase(int frame_cfg, int pay_cfg, int frames, flow_t mode);
    frame_len_t len;
    int pad;
    write_config(CFG_FRAME_BYTES, frame_cfg);
    write_config(CFG_PAYLOAD_BYTES, pay_cfg);
    @(negedge clk);
    flow = mode;
    len = active_frame_len();
    // Bring the stream back to a frame boundary under the new length.
    if (len >= 2 && fr_pos != 0) begin
      pad = (fr_pos >= len) ? 1 : int'(len) - int'(fr_pos);
      repeat (pad) queue_byte(byte_t'($urandom));
    end
    if (len < 22) begin
      repeat (8 * frames) queue_byte(byte_t'($urandom));
    end else begin
      repeat (frames) send_frame(int'(len), pay_cfg);
    end
    wait_drained();
  endtask

  initial begin : stimulus
    byte_t intro [$];
    int phase;
    int len;
    int pay;
    int frames;
    int room;
    intro = {8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, TYPE_DATA,
             8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h33, 8'hCC, 8'h96,
             8'h69, 8'h11, 8'hEE, 8'h22, 8'hDD, 8'h44,
             8'h00, 8'h00,
             8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
             MARK_0, MARK_1, MARK_2, MARK_3, 8'h00, 8'hFF, 8'h80, 8'h7F,
             MARK_0, MARK_1, MARK_2, 8'hE1, 8'hFF, MARK_0, MARK_1, MARK_2,
             MARK_3, 8'h01, 8'hFE};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: a data frame under the reset registers, pointer zero, markers in the payload.
    foreach (intro[k]) queue_byte(intro[k]);
    wait_drained();

    // Degenerate lengths, then the smallest frame with a one-byte payload.
    run_phase(0, 0, 2, FLOW_FREE);
    run_phase(1, 2027, 2, FLOW_BOTH);
    run_phase(21, 5, 3, FLOW_FREE);
    run_phase(22, 1, 12, FLOW_FREE);

    // Random phases until the item budget is spent.
    phase = 0;
    while (items_sent + 22 <= ITEM_TARGET) begin
      room = ITEM_TARGET - items_sent;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(97, 300)
                                        : $urandom_range(22, 96);
      if (len > room) len = room;
      case ($urandom_range(0, 6))
        0:       pay = len - 21;
        1:       pay = $urandom_range(len - 21, 2047);
        default: pay = $urandom_range(1, len - 21);
      endcase
      frames = $urandom_range(2, 6);
      if (frames * len > room) frames = room / len;
      run_phase(len, pay, frames, flow_t'(phase % 4));
      phase++;
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
